// ===== rtl/core/trcs_pkg.sv =====
// ----------------------------------------------------------------------------
// trcs_pkg
// Shared types and constants for the register machine step block.
// ----------------------------------------------------------------------------
package trcs_pkg;

  localparam int MEM_BYTES = 256;
  localparam int NUM_REGS  = 8;
  localparam int AW        = $clog2(MEM_BYTES);
  localparam int RW        = $clog2(NUM_REGS);

  localparam logic [1:0] CMD_WRITE = 2'd0;
  localparam logic [1:0] CMD_EXEC  = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [7:0] OP_HALT  = 8'h00;
  localparam logic [7:0] OP_NOP   = 8'h01;
  localparam logic [7:0] OP_ADD   = 8'h02;
  localparam logic [7:0] OP_SUB   = 8'h03;
  localparam logic [7:0] OP_MUL   = 8'h04;
  localparam logic [7:0] OP_DIV   = 8'h05;
  localparam logic [7:0] OP_CMP   = 8'h06;
  localparam logic [7:0] OP_MOVR  = 8'h07;
  localparam logic [7:0] OP_AND   = 8'h08;
  localparam logic [7:0] OP_OR    = 8'h09;
  localparam logic [7:0] OP_XOR   = 8'h0a;
  localparam logic [7:0] OP_NOT   = 8'h0b;
  localparam logic [7:0] OP_JE    = 8'h0c;
  localparam logic [7:0] OP_JNE   = 8'h0d;
  localparam logic [7:0] OP_JL    = 8'h0e;
  localparam logic [7:0] OP_JLE   = 8'h0f;
  localparam logic [7:0] OP_JG    = 8'h10;
  localparam logic [7:0] OP_JGE   = 8'h11;
  localparam logic [7:0] OP_JMP   = 8'h12;
  localparam logic [7:0] OP_LOAD  = 8'h13;
  localparam logic [7:0] OP_STORE = 8'h14;
  localparam logic [7:0] OP_MOVI  = 8'h15;
  localparam logic [7:0] OP_ADDI  = 8'h16;
  localparam logic [7:0] OP_SUBI  = 8'h17;
  localparam logic [7:0] OP_MULI  = 8'h18;
  localparam logic [7:0] OP_DIVI  = 8'h19;
  localparam logic [7:0] OP_LSH   = 8'h1a;
  localparam logic [7:0] OP_RSH   = 8'h1b;

  typedef struct packed {
    logic [1:0] command;
    logic [7:0] address;
    logic [7:0] data;
    logic [2:0] reg_select;
  } in_item_t;

  typedef struct packed {
    logic [7:0]  pc_value;
    logic [7:0]  opcode;
    logic        halted;
    logic        flag_equal;
    logic        flag_less;
    logic        flag_greater;
    logic [31:0] reg_value;
    logic [7:0]  mem_data;
  } out_item_t;

  // controller -> datapath
  typedef struct packed {
    logic         latch_in;    // capture command fields
    logic         mem_rd;      // read byte at mem_addr
    logic [AW-1:0] mem_addr;
    logic         mem_wr;      // write byte at mem_addr
    logic [7:0]   mem_wdata;
    logic         ir_shift;    // shift read byte into instruction register
    logic         ld_shift;    // shift read byte into load buffer
    logic         rd_capture;  // capture read byte into mem_data
    logic         exec;        // one-cycle ALU/flag/pc update
    logic         div_start;
    logic         div_step;
    logic         div_done;    // write quotient
    logic         load_done;   // write load buffer
    logic         halt_set;
    logic         pc_next;     // pc <- pc + 4
    logic         out_capture;
    logic         clear_op;
  } dp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0]    command;
    logic [AW-1:0] address;
    logic [7:0]    data;
    logic [7:0]    opcode;
    logic [AW-1:0] pc;
    logic [AW-1:0] target;
    logic [31:0]   ra_val;
    logic          halted;
  } dp_stat_t;

endpackage

// ===== rtl/core/trcs_datapath.sv =====
// ----------------------------------------------------------------------------
// trcs_datapath
// Registers, memory, ALU, serial divider and result register.
// ----------------------------------------------------------------------------
module trcs_datapath (
  input  logic                clk,
  input  logic                rst_n,
  input  trcs_pkg::in_item_t  in_item,
  input  trcs_pkg::dp_cmd_t   cmd,
  output trcs_pkg::dp_stat_t  stat,
  output trcs_pkg::out_item_t out_item
);

  localparam int AW = trcs_pkg::AW;
  localparam int RW = trcs_pkg::RW;

  logic [7:0]  mem [trcs_pkg::MEM_BYTES];
  logic [7:0]  mem_q;
  logic [31:0] regs_r [trcs_pkg::NUM_REGS];
  logic [AW-1:0] pc_r;
  logic        fe_r, fl_r, fg_r, halt_r;
  logic [31:0] ir_r, ld_r;
  logic [1:0]  cmd_r;
  logic [7:0]  addr_r, data_r;
  logic [2:0]  sel_r;
  logic [7:0]  rd_r;
  logic [31:0] q_r, rem_r, dvs_r;
  logic [32:0] rem_try;
  logic        dz_r;
  logic [7:0]  op;
  logic [RW-1:0] ia, ib;
  logic [31:0] ra, rb, imm, alu;
  logic        wr_alu, take;

  assign op  = ir_r[31:24];
  assign ia  = ir_r[23:21];
  assign ib  = ir_r[20:18];
  assign imm = ir_r & 32'h001fffff;
  assign ra  = regs_r[ia];
  assign rb  = regs_r[ib];

  always_ff @(posedge clk) begin
    if (cmd.mem_wr) mem[cmd.mem_addr] <= cmd.mem_wdata;
    if (cmd.mem_rd) mem_q <= mem[cmd.mem_addr];
  end

  always_comb begin
    alu = ra;
    wr_alu = 1'b1;
    case (op)
      trcs_pkg::OP_ADD:  alu = ra + rb;
      trcs_pkg::OP_SUB:  alu = ra - rb;
      trcs_pkg::OP_MUL:  alu = ra * rb;
      trcs_pkg::OP_MOVR: alu = rb;
      trcs_pkg::OP_AND:  alu = ra & rb;
      trcs_pkg::OP_OR:   alu = ra | rb;
      trcs_pkg::OP_XOR:  alu = ra ^ rb;
      trcs_pkg::OP_NOT:  alu = {31'd0, ra == 32'd0};
      trcs_pkg::OP_MOVI: alu = imm;
      trcs_pkg::OP_ADDI: alu = ra + imm;
      trcs_pkg::OP_SUBI: alu = ra - imm;
      trcs_pkg::OP_MULI: alu = ra * imm;
      trcs_pkg::OP_LSH:  alu = (imm >= 32'd32) ? 32'd0 : ra << imm[4:0];
      trcs_pkg::OP_RSH:  alu = (imm >= 32'd32) ? 32'd0 : ra >> imm[4:0];
      default:           wr_alu = 1'b0;
    endcase
  end

  always_comb begin
    case (op)
      trcs_pkg::OP_JE:  take = fe_r;
      trcs_pkg::OP_JNE: take = !fe_r;
      trcs_pkg::OP_JL:  take = fl_r;
      trcs_pkg::OP_JLE: take = fe_r | fl_r;
      trcs_pkg::OP_JG:  take = fg_r;
      trcs_pkg::OP_JGE: take = fe_r | fg_r;
      default:          take = 1'b1;
    endcase
  end

  // restoring divide, one quotient bit per step
  assign rem_try = {rem_r, q_r[31]} - {1'b0, dvs_r};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      q_r   <= ra;
      rem_r <= 32'd0;
      dvs_r <= (op == trcs_pkg::OP_DIV) ? rb : imm;
      dz_r  <= ((op == trcs_pkg::OP_DIV) ? rb : imm) == 32'd0;
    end else if (cmd.div_step) begin
      if (!rem_try[32]) begin
        rem_r <= rem_try[31:0];
        q_r   <= {q_r[30:0], 1'b1};
      end else begin
        rem_r <= {rem_r[30:0], q_r[31]};
        q_r   <= {q_r[30:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch_in) begin
      cmd_r  <= in_item.command;
      addr_r <= in_item.address;
      data_r <= in_item.data;
      sel_r  <= in_item.reg_select;
    end
    if (cmd.ir_shift) ir_r <= {ir_r[23:0], mem_q};
    if (cmd.ld_shift) ld_r <= {ld_r[23:0], mem_q};
    if (cmd.latch_in) rd_r <= 8'd0;
    else if (cmd.rd_capture) rd_r <= mem_q;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < trcs_pkg::NUM_REGS; i++) regs_r[i] <= 32'd0;
      pc_r <= '0; fe_r <= 1'b0; fl_r <= 1'b0; fg_r <= 1'b0; halt_r <= 1'b0;
    end else begin
      if (cmd.halt_set) halt_r <= 1'b1;
      if (cmd.pc_next) pc_r <= pc_r + AW'(4);
      if (cmd.div_done) regs_r[ia] <= dz_r ? 32'hffffffff : q_r;
      // last byte is still in mem_q on the final load cycle
      if (cmd.load_done) regs_r[ia] <= {ld_r[23:0], mem_q};
      if (cmd.exec) begin
        if (op == trcs_pkg::OP_NOP) pc_r <= pc_r + AW'(1);
        else if (op == trcs_pkg::OP_CMP) begin
          fe_r <= ra == rb; fl_r <= ra < rb; fg_r <= ra > rb;
          pc_r <= pc_r + AW'(4);
        end else if (op >= trcs_pkg::OP_JE && op <= trcs_pkg::OP_JMP)
          pc_r <= take ? imm[AW-1:0] : pc_r + AW'(4);
        else if (wr_alu) begin
          regs_r[ia] <= alu;
          pc_r <= pc_r + AW'(4);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_capture) begin
      out_item.pc_value     <= 8'(pc_r);
      out_item.opcode       <= cmd.clear_op ? 8'd0 : op;
      out_item.halted       <= halt_r;
      out_item.flag_equal   <= fe_r;
      out_item.flag_less    <= fl_r;
      out_item.flag_greater <= fg_r;
      out_item.reg_value    <= regs_r[sel_r];
      out_item.mem_data     <= rd_r;
    end
  end

  assign stat.command = cmd_r;
  assign stat.address = addr_r[AW-1:0];
  assign stat.data    = data_r;
  assign stat.opcode  = op;
  assign stat.pc      = pc_r;
  assign stat.target  = imm[AW-1:0];
  assign stat.ra_val  = ra;
  assign stat.halted  = halt_r;

endmodule

// ===== rtl/core/trcs_ctrl.sv =====
// ----------------------------------------------------------------------------
// trcs_ctrl
// Sequencer: memory clearing, byte fetches, divide steps, result strobe.
// ----------------------------------------------------------------------------
module trcs_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  output logic               out_valid,
  input  trcs_pkg::dp_stat_t stat,
  output trcs_pkg::dp_cmd_t  cmd
);

  localparam int AW = trcs_pkg::AW;

  localparam logic [3:0] S_CLR   = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_DEC   = 4'd2;
  localparam logic [3:0] S_FETCH = 4'd3;
  localparam logic [3:0] S_EXEC  = 4'd4;
  localparam logic [3:0] S_DIV   = 4'd5;
  localparam logic [3:0] S_LOAD  = 4'd6;
  localparam logic [3:0] S_STORE = 4'd7;
  localparam logic [3:0] S_OUT   = 4'd8;
  localparam logic [3:0] S_RDW   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [AW-1:0] clr_r, clr_nxt;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          clrop_r, clrop_nxt;
  logic          ov_r, ov_nxt;
  logic [AW-1:0] base;

  assign busy = (state_r != S_IDLE);
  assign out_valid = ov_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR; clr_r <= '0; cnt_r <= '0; clrop_r <= 1'b1; ov_r <= 1'b0;
    end else begin
      state_r <= state_nxt; clr_r <= clr_nxt; cnt_r <= cnt_nxt;
      clrop_r <= clrop_nxt; ov_r <= ov_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r; clr_nxt = clr_r; cnt_nxt = cnt_r;
    clrop_nxt = clrop_r; ov_nxt = 1'b0;
    cmd = '0;
    cmd.clear_op = clrop_r;
    base = (state_r == S_LOAD) ? stat.target : stat.pc;
    case (state_r)
      S_CLR: begin
        cmd.mem_wr = 1'b1; cmd.mem_addr = clr_r;
        clr_nxt = clr_r + AW'(1);
        if (clr_r == AW'(trcs_pkg::MEM_BYTES - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          cmd.latch_in = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        clrop_nxt = 1'b1; cnt_nxt = '0;
        case (stat.command)
          trcs_pkg::CMD_WRITE: begin
            cmd.mem_wr = 1'b1; cmd.mem_addr = stat.address;
            cmd.mem_wdata = stat.data; state_nxt = S_OUT;
          end
          trcs_pkg::CMD_READ: begin
            cmd.mem_rd = 1'b1; cmd.mem_addr = stat.address; state_nxt = S_RDW;
          end
          trcs_pkg::CMD_EXEC: state_nxt = stat.halted ? S_OUT : S_FETCH;
          default: state_nxt = S_OUT;
        endcase
      end
      S_RDW: begin
        cmd.rd_capture = 1'b1; state_nxt = S_OUT;
      end
      S_FETCH, S_LOAD: begin
        // cnt 0..3 issue reads, 1..4 shift data
        if (cnt_r < 6'd4) begin
          cmd.mem_rd = 1'b1; cmd.mem_addr = base + AW'(cnt_r[1:0]);
        end
        if (cnt_r != 6'd0) begin
          cmd.ir_shift = (state_r == S_FETCH); cmd.ld_shift = (state_r == S_LOAD);
        end
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd4) begin
          cnt_nxt = '0;
          if (state_r == S_FETCH) state_nxt = S_EXEC;
          else begin
            cmd.load_done = 1'b1; cmd.pc_next = 1'b1; state_nxt = S_OUT;
          end
        end
      end
      S_EXEC: begin
        clrop_nxt = 1'b0;
        case (stat.opcode)
          trcs_pkg::OP_HALT: begin cmd.halt_set = 1'b1; state_nxt = S_OUT; end
          trcs_pkg::OP_DIV, trcs_pkg::OP_DIVI: begin
            cmd.div_start = 1'b1; state_nxt = S_DIV;
          end
          trcs_pkg::OP_LOAD:  state_nxt = S_LOAD;
          trcs_pkg::OP_STORE: state_nxt = S_STORE;
          default: begin cmd.exec = 1'b1; state_nxt = S_OUT; end
        endcase
      end
      S_DIV: begin
        cmd.div_step = 1'b1; cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd32) begin
          cmd.div_step = 1'b0; cmd.div_done = 1'b1; cmd.pc_next = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_STORE: begin
        cmd.mem_wr = 1'b1; cmd.mem_addr = stat.target + AW'(cnt_r[1:0]);
        case (cnt_r[1:0])
          2'd0:    cmd.mem_wdata = stat.ra_val[31:24];
          2'd1:    cmd.mem_wdata = stat.ra_val[23:16];
          2'd2:    cmd.mem_wdata = stat.ra_val[15:8];
          default: cmd.mem_wdata = stat.ra_val[7:0];
        endcase
        cnt_nxt = cnt_r + 6'd1;
        if (cnt_r == 6'd3) begin cmd.pc_next = 1'b1; state_nxt = S_OUT; end
      end
      S_OUT: begin
        cmd.out_capture = 1'b1; ov_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/core/tiny_register_cpu_step.sv =====
// ----------------------------------------------------------------------------
// tiny_register_cpu_step
// 32-bit register machine with byte memory, one command per item.
// ----------------------------------------------------------------------------
// channel  | ports                       | handshake
// input    | in_item                     | start & !busy
// result   | out_item                    | out_valid, one cycle
//
// Write/read/unused commands need no fetch. Execute: a fetch of four bytes, then
// the ALU/jump op, a load of four bytes, a store of four bytes or the bit-serial
// divide; the divider and the single memory port set the worst case.
// After reset busy is high while all MEM_BYTES bytes of memory are cleared.
// The receiver cannot stall; each result is shown for one cycle.
module tiny_register_cpu_step (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  trcs_pkg::in_item_t  in_item,
  output logic                out_valid,
  output trcs_pkg::out_item_t out_item
);

  trcs_pkg::dp_cmd_t  cmd;
  trcs_pkg::dp_stat_t stat;

  trcs_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .out_valid(out_valid), .stat(stat), .cmd(cmd)
  );

  trcs_datapath u_dp (
    .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd),
    .stat(stat), .out_item(out_item)
  );

`ifndef NO_ASSERTIONS
  a_out_then_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !busy) else $error("result while busy");
  a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_single_strobe: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result");
`endif

endmodule
